// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the mutex table.
// Depends on nothing; the using module must declare clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is applied.
`define HMT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define HMT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/hmt_pkg.sv =====
// Types and constants of the hardware mutex table.
// No dependencies; the interfaces, the top level and the checker import this package.
package hmt_pkg;

  localparam int NUM_MUTEXES = 16;
  localparam int SLOT_W      = 4;
  localparam int ID_W        = 8;
  localparam int STATUS_W    = 3;

  typedef enum logic [1:0] {
    REQ_CREATE  = 2'd0,
    REQ_LOCK    = 2'd1,
    REQ_UNLOCK  = 2'd2,
    REQ_RELEASE = 2'd3
  } req_type_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_GRANTED   = 3'd1,
    ST_QUEUED    = 3'd2,
    ST_KILL      = 3'd3,
    ST_WRONG     = 3'd4,
    ST_NOT_OWNER = 3'd5,
    ST_FULL      = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_META  = 2'd1,
    S_WAIT  = 2'd2,
    S_FINAL = 2'd3
  } hmt_state_t;

  typedef struct packed {
    logic            exists;
    logic [ID_W-1:0] owner;
    logic            held;
    logic [ID_W-1:0] holder;
  } slot_info_t;

endpackage

// ===== hw/rtl/hmt_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on hmt_pkg for field widths.
interface hmt_req_if import hmt_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [SLOT_W-1:0] mutex_id;
  logic [ID_W-1:0]   proc_id;
  logic [ID_W-1:0]   thread_id;
  modport source(output valid, req_type, mutex_id, proc_id, thread_id, input ready);
  modport sink(input valid, req_type, mutex_id, proc_id, thread_id, output ready);
endinterface

interface hmt_res_if import hmt_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic                woken_valid;
  logic [ID_W-1:0]     woken_proc;
  logic [ID_W-1:0]     woken_thread;
  logic                last;
  modport source(output valid, status, slot, woken_valid, woken_proc, woken_thread, last,
                 input ready);
  modport sink(input valid, status, slot, woken_valid, woken_proc, woken_thread, last,
               output ready);
endinterface

// ===== hw/rtl/hmt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ===== hw/rtl/hw_mutex_table_fifo_handoff.sv =====
// Hardware mutex table: top level with the request sequencer.
// Depends on hmt_pkg, hmt_if and hmt_ram.
//
// A table of sixteen lock slots with a FIFO of WAIT_DEPTH waiting threads per
// slot. Each request transaction produces one result transaction, except a
// release-all, which produces one result per slot it releases (in ascending
// slot order) followed by a final result with last set. Slot state lives in a
// small metadata RAM with one valid bit per slot, so the table reads as empty
// right after reset with no clearing pass; waiter ids live in a second RAM
// indexed by slot and queue position. Create, lock, and unlock without a
// handoff finish in the metadata state; an unlock that hands the lock to a
// waiter also passes through the wait state. A release-all walks every slot
// through the single metadata read port, one slot per cycle unless a result
// stalls on a full output register, plus a wait state per handoff, then emits
// the final result. A new request is accepted while the last result still waits
// in the output register; the sequencer only stalls to emit into a full one.
module hw_mutex_table_fifo_handoff import hmt_pkg::*; #(
  parameter int WAIT_DEPTH = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  hmt_req_if.sink  in_req,
  hmt_res_if.source out_res
);
  localparam int PW    = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int CW    = $clog2(WAIT_DEPTH + 1);
  localparam int INFO_W = $bits(slot_info_t);
  localparam int MW    = INFO_W + PW + CW;
  localparam int WDEPTH = NUM_MUTEXES << PW;

  hmt_state_t state_r, state_nxt;

  logic [1:0]        req_r;
  logic [ID_W-1:0]   proc_r;
  logic [ID_W-1:0]   thr_r;
  logic [SLOT_W-1:0] cur_r, cur_nxt;
  logic [NUM_MUTEXES-1:0] vld_r;

  // Output register.
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic                out_wv_r;
  logic [ID_W-1:0]     out_wp_r;
  logic [ID_W-1:0]     out_wt_r;
  logic                out_last_r;

  // Memory ports.
  logic              meta_we, meta_re;
  logic [SLOT_W-1:0] meta_waddr, meta_raddr;
  logic [MW-1:0]     meta_wdata, meta_rdata;
  logic                      wt_we, wt_re;
  logic [SLOT_W+PW-1:0]      wt_waddr, wt_raddr;
  logic [2*ID_W-1:0]         wt_wdata, wt_rdata;

  // Decoded slot state.
  slot_info_t   info;
  logic [PW-1:0] head;
  logic [CW-1:0] count;
  logic [MW-1:0] meta_cur;
  logic [PW:0]   qsum;
  logic [PW-1:0] qpos, head_inc;
  status_t       lock_st;
  logic          unlock_ok, rel_match, has_waiter, last_slot, can_emit, in_fire;

  // Emit request.
  logic                emit;
  status_t             e_status;
  logic [SLOT_W-1:0]   e_slot;
  logic                e_wv;
  logic [ID_W-1:0]     e_wp;
  logic [ID_W-1:0]     e_wt;
  logic                e_last;

  hmt_ram #(.WIDTH(MW), .DEPTH(NUM_MUTEXES)) u_meta_ram (
    .clk, .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .re(meta_re), .raddr(meta_raddr), .rdata(meta_rdata)
  );

  hmt_ram #(.WIDTH(2*ID_W), .DEPTH(WDEPTH)) u_wait_ram (
    .clk, .we(wt_we), .waddr(wt_waddr), .wdata(wt_wdata),
    .re(wt_re), .raddr(wt_raddr), .rdata(wt_rdata)
  );

  assign in_fire  = in_req.valid && in_req.ready;
  assign can_emit = !out_valid_r || out_res.ready;

  // A slot never written reads as all zero.
  assign meta_cur   = vld_r[cur_r] ? meta_rdata : '0;
  assign info       = meta_cur[MW-1 -: INFO_W];
  assign head       = meta_cur[PW+CW-1 -: PW];
  assign count      = meta_cur[CW-1:0];
  assign has_waiter = (count != '0);
  assign last_slot  = (cur_r == SLOT_W'(NUM_MUTEXES - 1));

  always_comb begin
    qsum = {1'b0, head} + (PW+1)'(count);
    if (qsum >= (PW+1)'(WAIT_DEPTH)) begin
      qsum = qsum - (PW+1)'(WAIT_DEPTH);
    end
    qpos     = qsum[PW-1:0];
    head_inc = (head == PW'(WAIT_DEPTH - 1)) ? '0 : head + PW'(1);
  end

  always_comb begin
    if (!info.exists) begin
      lock_st = ST_KILL;
    end else if (info.owner != proc_r) begin
      lock_st = ST_WRONG;
    end else if (!info.held || info.holder == thr_r) begin
      lock_st = ST_GRANTED;
    end else if (count == CW'(WAIT_DEPTH)) begin
      lock_st = ST_FULL;
    end else begin
      lock_st = ST_QUEUED;
    end
  end

  assign unlock_ok = info.exists && info.held && (info.holder == thr_r);
  assign rel_match = unlock_ok;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_META;
        end
      end
      S_META: begin
        case (req_r)
          REQ_CREATE, REQ_LOCK: begin
            if (can_emit) state_nxt = S_IDLE;
          end
          REQ_UNLOCK: begin
            if (unlock_ok && has_waiter) begin
              state_nxt = S_WAIT;
            end else if (can_emit) begin
              state_nxt = S_IDLE;
            end
          end
          default: begin
            if (rel_match && has_waiter) begin
              state_nxt = S_WAIT;
            end else if (!rel_match || can_emit) begin
              state_nxt = last_slot ? S_FINAL : S_META;
            end
          end
        endcase
      end
      S_WAIT: begin
        if (can_emit) begin
          if (req_r != REQ_RELEASE) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = last_slot ? S_FINAL : S_META;
          end
        end
      end
      S_FINAL: begin
        if (can_emit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    in_req.ready = 1'b0;
    meta_we = 1'b0; meta_waddr = cur_r; meta_wdata = meta_cur;
    meta_re = 1'b0; meta_raddr = cur_r + SLOT_W'(1);
    wt_we = 1'b0; wt_waddr = {cur_r, qpos}; wt_wdata = {proc_r, thr_r};
    wt_re = 1'b0; wt_raddr = {cur_r, head};
    cur_nxt = cur_r;
    emit = 1'b0; e_status = ST_OK; e_slot = cur_r; e_wv = 1'b0;
    e_wp = '0; e_wt = '0; e_last = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_req.ready = 1'b1;
        if (in_req.valid) begin
          meta_re    = 1'b1;
          meta_raddr = (in_req.req_type == REQ_RELEASE) ? '0 : in_req.mutex_id;
          cur_nxt    = meta_raddr;
        end
      end
      S_META: begin
        case (req_r)
          REQ_CREATE: begin
            if (can_emit) begin
              emit = 1'b1;
              if (!info.exists) begin
                meta_we    = 1'b1;
                meta_wdata = {1'b1, proc_r, 1'b0, {ID_W{1'b0}}, {PW{1'b0}}, {CW{1'b0}}};
              end
            end
          end
          REQ_LOCK: begin
            if (can_emit) begin
              emit     = 1'b1;
              e_status = lock_st;
              if (lock_st == ST_GRANTED) begin
                meta_we    = 1'b1;
                meta_wdata = {info.exists, info.owner, 1'b1, thr_r, head, count};
              end else if (lock_st == ST_QUEUED) begin
                meta_we    = 1'b1;
                meta_wdata = {info, head, count + CW'(1)};
                wt_we      = 1'b1;
              end
            end
          end
          REQ_UNLOCK: begin
            if (unlock_ok && has_waiter) begin
              wt_re = 1'b1;
            end else if (can_emit) begin
              emit = 1'b1;
              if (unlock_ok) begin
                meta_we    = 1'b1;
                meta_wdata = {info.exists, info.owner, 1'b0, {ID_W{1'b0}}, head, count};
              end else begin
                e_status = ST_NOT_OWNER;
              end
            end
          end
          default: begin
            e_last = 1'b0;
            if (rel_match && has_waiter) begin
              wt_re = 1'b1;
            end else if (!rel_match || can_emit) begin
              if (rel_match) begin
                emit       = 1'b1;
                meta_we    = 1'b1;
                meta_wdata = {info.exists, info.owner, 1'b0, {ID_W{1'b0}}, head, count};
              end
              if (!last_slot) begin
                meta_re = 1'b1;
                cur_nxt = cur_r + SLOT_W'(1);
              end
            end
          end
        endcase
      end
      S_WAIT: begin
        if (can_emit) begin
          emit       = 1'b1;
          e_wv       = 1'b1;
          e_wp       = wt_rdata[2*ID_W-1 -: ID_W];
          e_wt       = wt_rdata[ID_W-1:0];
          e_last     = (req_r != REQ_RELEASE);
          meta_we    = 1'b1;
          meta_wdata = {info.exists, info.owner, 1'b1, e_wt, head_inc, count - CW'(1)};
          if (req_r == REQ_RELEASE && !last_slot) begin
            meta_re = 1'b1;
            cur_nxt = cur_r + SLOT_W'(1);
          end
        end
      end
      S_FINAL: begin
        if (can_emit) begin
          emit   = 1'b1;
          e_slot = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (meta_we) begin
        vld_r[meta_waddr] <= 1'b1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (in_fire) begin
      req_r  <= in_req.req_type;
      proc_r <= in_req.proc_id;
      thr_r  <= in_req.thread_id;
    end
    if (emit) begin
      out_status_r <= e_status;
      out_slot_r   <= e_slot;
      out_wv_r     <= e_wv;
      out_wp_r     <= e_wp;
      out_wt_r     <= e_wt;
      out_last_r   <= e_last;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.status       = out_status_r;
  assign out_res.slot         = out_slot_r;
  assign out_res.woken_valid  = out_wv_r;
  assign out_res.woken_proc   = out_wp_r;
  assign out_res.woken_thread = out_wt_r;
  assign out_res.last         = out_last_r;
endmodule

// ===== hw/rtl/hmt_checker.sv =====
// Port-level checker for the mutex table, bound to the top level.
// Depends on hmt_pkg and assert_macros.svh.
`include "assert_macros.svh"
module hmt_checker import hmt_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] status,
  input logic [SLOT_W-1:0]   slot,
  input logic                woken_valid,
  input logic                last
);
  logic stalled;

  assign stalled = out_valid && !out_ready;

  `HMT_ASSERT(a_hold, stalled |=> out_valid && $stable(status) && $stable(slot), "result moved in stall")
  `HMT_ASSERT(a_code, out_valid |-> status <= ST_FULL, "undefined status code")
  `HMT_ASSERT(a_wake, out_valid && woken_valid |-> status == ST_OK, "handoff with error status")
  `HMT_ASSERT(a_errlast, out_valid && status != ST_OK |-> last, "error result not final")
endmodule

bind hw_mutex_table_fifo_handoff hmt_checker u_hmt_checker (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_res.valid), .out_ready(out_res.ready),
  .status(out_res.status), .slot(out_res.slot),
  .woken_valid(out_res.woken_valid), .last(out_res.last)
);
